### design/spiral_index_to_coordinate_core_macros.svh
// assertion macros for the spiral index to coordinate core
// used by the top level only, no other dependencies
`ifndef SPIRAL_INDEX_TO_COORDINATE_CORE_MACROS_SVH
`define SPIRAL_INDEX_TO_COORDINATE_CORE_MACROS_SVH

// implication checked in the same cycle, ignored while in reset
`define SITC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle, ignored while in reset
`define SITC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication checked in the next cycle, also across reset
`define SITC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sitc_pkg.sv
// shared constants for the spiral index to coordinate core
// no dependencies
package sitc_pkg;

  // width of the signed coordinate outputs
  localparam int POS_W = 12;

  // default number of index bits used
  localparam int INDEX_W_DEF = 20;

endpackage

### design/spiral_index_to_coordinate_core.sv
// Square spiral index to coordinate. Each cell index becomes the signed (x, z)
// position of that cell on a square spiral around the origin. The pipeline takes
// one index per cycle while the result channel is not stalled, and has one stage
// per bit of the integer square root, then one stage that picks the nearest square
// and one that applies the side formulas. A stall on the result channel freezes
// the whole pipeline and is passed back to the input. Index bits above INDEX_WIDTH
// are ignored, and coordinates wrap to 12 bits. No state is kept between items.
// depends on sitc_pkg, sitc_root_stage, sitc_map and the assertion macro header
`include "spiral_index_to_coordinate_core_macros.svh"

module spiral_index_to_coordinate_core #(
  parameter int INDEX_WIDTH = sitc_pkg::INDEX_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [INDEX_WIDTH-1:0]            in_cell_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sitc_pkg::POS_W-1:0] out_pos_x,
  output logic signed [sitc_pkg::POS_W-1:0] out_pos_z
);

  localparam int ROOT_W = (INDEX_WIDTH + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // whole pipeline advances unless a finished result is held off
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // square root chain
  logic              vld_c  [0:ROOT_W];
  logic [RAD_W-1:0]  rad_c  [0:ROOT_W];
  logic [ROOT_W-1:0] root_c [0:ROOT_W];
  logic [REM_W-1:0]  rem_c  [0:ROOT_W];

  assign vld_c[0]  = in_valid;
  assign rad_c[0]  = RAD_W'(in_cell_index);
  assign root_c[0] = '0;
  assign rem_c[0]  = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    sitc_root_stage #(
      .ROOT_W(ROOT_W)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .in_valid (vld_c[k]),
      .in_rad   (rad_c[k]),
      .in_root  (root_c[k]),
      .in_rem   (rem_c[k]),
      .out_valid(vld_c[k+1]),
      .out_rad  (rad_c[k+1]),
      .out_root (root_c[k+1]),
      .out_rem  (rem_c[k+1])
    );
  end

  // nearest square and coordinate formulas
  sitc_map #(
    .ROOT_W(ROOT_W)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (vld_c[ROOT_W]),
    .in_root  (root_c[ROOT_W]),
    .in_rem   (rem_c[ROOT_W]),
    .out_valid(out_valid),
    .out_x    (out_pos_x),
    .out_z    (out_pos_z)
  );

  // checks
  `SITC_ASSERT_NOW(a_backpressure, out_valid && out_stall, in_stall, "input not stalled")
  `SITC_ASSERT_NEXT(a_drain, out_valid && !out_stall && !u_map.vld_a_r, !out_valid, "dup result")
  `SITC_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "pipeline not empty after reset")
  `SITC_ASSERT_NEXT(a_root_enter, vld_c[ROOT_W] && !in_stall, u_map.vld_a_r, "root result lost")

endmodule

### design/sitc_root_stage.sv
// one registered step of the digit-by-digit square root, one root bit per stage
// no package dependencies
module sitc_root_stage #(
  parameter int ROOT_W = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_rad,
  input  logic [ROOT_W-1:0]   in_root,
  input  logic [ROOT_W+1:0]   in_rem,
  output logic                out_valid,
  output logic [2*ROOT_W-1:0] out_rad,
  output logic [ROOT_W-1:0]   out_root,
  output logic [ROOT_W+1:0]   out_rem
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic             valid_r;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh   = {in_rem[ROOT_W-1:0], in_rad[RAD_W-1 -: 2]};
    trial    = {in_root, 2'b01};
    fits     = (rem_sh >= trial);
    rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
    root_nxt = {in_root[ROOT_W-2:0], fits};
    rad_nxt  = {in_rad[RAD_W-3:0], 2'b00};
  end

  // valid bit, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_root  = root_r;
  assign out_rem   = rem_r;

endmodule

### design/sitc_map.sv
// nearest square selection and spiral side formulas, two register stages
// depends on sitc_pkg for the coordinate width
module sitc_map #(
  parameter int ROOT_W = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [ROOT_W-1:0]                in_root,
  input  logic [ROOT_W+1:0]                in_rem,
  output logic                             out_valid,
  output logic signed [sitc_pkg::POS_W-1:0] out_x,
  output logic signed [sitc_pkg::POS_W-1:0] out_z
);

  localparam int REM_W = ROOT_W + 2;
  localparam int R_W   = ROOT_W + 1;
  localparam int PW    = sitc_pkg::POS_W;

  // stage a: nearest square root and distance to it
  logic             vld_a_r;
  logic [R_W-1:0]   r_a_r, r_a_nxt;
  logic [REM_W-1:0] diff_a_r, diff_a_nxt;
  logic             ge_a_r, ge_a_nxt;
  logic             up;

  // round up when the remainder passes the root, ties stay on the lower square
  always_comb begin
    up         = (in_rem > REM_W'(in_root));
    r_a_nxt    = R_W'(in_root) + R_W'(up);
    diff_a_nxt = up ? (REM_W'({in_root, 1'b1}) - in_rem) : in_rem;
    ge_a_nxt   = !up;
  end

  // stage b: side formulas
  logic                 vld_b_r;
  logic signed [PW-1:0] x_r, x_nxt;
  logic signed [PW-1:0] z_r, z_nxt;
  logic signed [PW-1:0] h;
  logic signed [PW-1:0] d;

  // half side length and offset along the side, wrapped to output width
  always_comb begin
    h = PW'(r_a_r >> 1) + PW'(r_a_r[0]);
    d = PW'(diff_a_r);
    unique case ({r_a_r[0], ge_a_r})
      2'b01: begin
        x_nxt = h;
        z_nxt = d - h;
      end
      2'b00: begin
        x_nxt = h - d;
        z_nxt = -h;
      end
      2'b11: begin
        x_nxt = -h;
        z_nxt = h - PW'(1) - d;
      end
      default: begin
        x_nxt = d - h;
        z_nxt = h - PW'(1);
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      r_a_r    <= r_a_nxt;
      diff_a_r <= diff_a_nxt;
      ge_a_r   <= ge_a_nxt;
      x_r      <= x_nxt;
      z_r      <= z_nxt;
    end
  end

  assign out_valid = vld_b_r;
  assign out_x     = x_r;
  assign out_z     = z_r;

endmodule

### dv/spiral_index_to_coordinate_core_tb.sv
// testbench for spiral_index_to_coordinate_core: drives cell indexes, predicts the
// spiral (x, z) position of each and checks every result transfer in order
// depends on sitc_pkg and the spiral_index_to_coordinate_core top level
`timescale 1ns / 1ps

module spiral_index_to_coordinate_core_tb;

  localparam int IDX_W     = sitc_pkg::INDEX_W_DEF;
  localparam int POS_W     = sitc_pkg::POS_W;
  localparam int LATENCY   = (IDX_W + 1) / 2 + 2;
  localparam longint MAX_INDEX = (longint'(1) << IDX_W) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_GAP   = 24;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
  } spiral_pos_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [IDX_W-1:0]        in_cell_index;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_z;

  spiral_pos_t pos_expect_q[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          results_checked;
  int          err_count;
  int          cycle_count;

  spiral_index_to_coordinate_core #(
    .INDEX_WIDTH(IDX_W)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_index(in_cell_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pos_x    (out_pos_x),
    .out_pos_z    (out_pos_z)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // position of a cell on the square spiral, wrapped to the output width
  function automatic spiral_pos_t spiral_cell(input logic [IDX_W-1:0] idx);
    spiral_pos_t p;
    longint n, root, trial, r, sq, h, x, z;
    n = longint'(idx);
    root = 0;
    // bitwise floor square root
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    // nearest square, the lower one on a tie
    r = (n - root * root > (root + 1) * (root + 1) - n) ? root + 1 : root;
    sq = r * r;
    if (r[0] == 1'b0) begin
      h = r / 2;
      if (n >= sq) begin
        x = h;
        z = -h + (n - sq);
      end else begin
        x = h - (sq - n);
        z = -h;
      end
    end else begin
      h = (r + 1) / 2;
      if (n >= sq) begin
        x = -h;
        z = h - 1 - (n - sq);
      end else begin
        x = -h + (sq - n);
        z = h - 1;
      end
    end
    p.idx = idx;
    p.x   = x[POS_W-1:0];
    p.z   = z[POS_W-1:0];
    return p;
  endfunction

  // one index transfer, with a random idle gap ahead of it
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pos_expect_q.push_back(spiral_cell(idx));
    items_sent++;
  endtask

  // hold the sender off until every expected position has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pos_expect_q.size() != 0) @(posedge clk);
  endtask

  // zero, squares and their neighbors, midpoints between squares, bit patterns
  task automatic test_directed();
    int corner_idx[] = '{0, 1, 2, 3, 4, 5, 6, 8, 9, 12, 13, 16, 25, 30, 31, 32,
                         1046528, 1046529, 1046530, 1047552, 1047553,
                         'h80000, 'haaaaa, 'h55555, 'hfffff};
    foreach (corner_idx[i]) send_index(corner_idx[i][IDX_W-1:0]);
  endtask

  // indexes spread over the whole range
  task automatic test_uniform(input int count);
    for (int i = 0; i < count; i++) send_index(IDX_W'($urandom));
  endtask

  // indexes within one side length of a square, to hit both parities and both sides
  task automatic test_near_squares(input int count);
    longint r, n;
    for (int i = 0; i < count; i++) begin
      r = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(1024);
      n = r * r + longint'($urandom_range(int'(2 * r))) - r;
      if (n < 0) n = 0;
      if (n > MAX_INDEX) n = MAX_INDEX;
      send_index(n[IDX_W-1:0]);
    end
  endtask

  // random mix under one idling pattern, then a full drain
  task automatic test_idle_phase(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    test_uniform(110);
    test_near_squares(105);
    wait_drained();
  endtask

  // receiver stall, decided at the falling edge
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    spiral_pos_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pos_expect_q.size() == 0) begin
        $display("%0t: unexpected result x %0d z %0d", $time, out_pos_x, out_pos_z);
        err_count++;
      end else begin
        want = pos_expect_q.pop_front();
        results_checked++;
        if (out_pos_x !== want.x) begin
          $display("%0t: index %0d pos_x expected %0d got %0d",
                   $time, want.idx, want.x, out_pos_x);
          err_count++;
        end
        if (out_pos_z !== want.z) begin
          $display("%0t: index %0d pos_z expected %0d got %0d",
                   $time, want.idx, want.z, out_pos_z);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pos_expect_q.size());
      $display("spiral_index_to_coordinate_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cell_index   = '0;
    out_stall       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    results_checked = 0;
    err_count       = 0;
    cycle_count     = 0;

    // synchronous reset, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_drained();
    test_idle_phase(0, 0);
    test_idle_phase(78, 0);
    test_idle_phase(0, 78);
    test_idle_phase(23, 23);

    // quiet tail to catch stray results
    recv_stall_pct = 0;
    repeat (2 * LATENCY) @(posedge clk);
    if (pos_expect_q.size() != 0) begin
      $display("%0d predicted positions never arrived", pos_expect_q.size());
      err_count++;
    end

    $display("sent %0d cell indexes (corners, full range, near squares) under four",
             items_sent);
    $display("idling patterns; %0d positions checked, %0d mismatches",
             results_checked, err_count);
    if (err_count == 0) begin
      $display("spiral_index_to_coordinate_core regression: pass");
    end else begin
      $display("spiral_index_to_coordinate_core regression: fail");
    end
    $finish;
  end

endmodule

### spiral_index_to_coordinate_core.f
+incdir+design
design/sitc_pkg.sv
design/sitc_root_stage.sv
design/sitc_map.sv
design/spiral_index_to_coordinate_core.sv
dv/spiral_index_to_coordinate_core_tb.sv
